// ----- rtl/rmbd_pkg.sv -----
// Package for the RGBA mipmap 2x2 box downsampler.
// Holds sizes, channel widths and register codes used by rmbd_lane and the top level.
// No dependencies.
package rmbd_pkg;

   localparam int MAX_WIDTH = 1024;

   localparam int DIM_W = 11;
   localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EXT_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
   localparam int BUF_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   localparam int NUM_CH = 4;
   localparam int CH_W = 8;
   localparam int PAIR_W = CH_W + 1;
   localparam int QUAD_W = CH_W + 2;
   localparam int ROW_W = NUM_CH * PAIR_W;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DIM_W-1:0] WIDTH_RESET = DIM_W'(1024);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [CH_W-1:0] chan_type;
   typedef logic [PAIR_W-1:0] pair_type;

   function automatic logic [EXT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [EXT_W-1:0] e;
      e = EXT_W'(v);
      if (e > EXT_W'(MAX_WIDTH)) begin
         e = EXT_W'(MAX_WIDTH);
      end
      if (e == '0) begin
         e = EXT_W'(1);
      end
      return e;
   endfunction

endpackage

// ----- rtl/rmbd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the row buffer of pair sums; no package dependency.
module rmbd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 512,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rmbd_lane.sv -----
// One color channel lane of the box filter: horizontal pair sum and the
// final four-value sum truncated to the average. Depends on rmbd_pkg.
module rmbd_lane (
   input  rmbd_pkg::chan_type left_byte,
   input  rmbd_pkg::chan_type right_byte,
   output rmbd_pkg::pair_type pair_sum,
   input  rmbd_pkg::pair_type lower_pair,
   input  rmbd_pkg::pair_type upper_pair,
   output rmbd_pkg::chan_type avg
);
   import rmbd_pkg::*;

   logic [QUAD_W-1:0] quad_sum;

   assign pair_sum = PAIR_W'(left_byte) + PAIR_W'(right_byte);
   assign quad_sum = QUAD_W'(lower_pair) + QUAD_W'(upper_pair);
   assign avg = quad_sum[QUAD_W-1:2];

endmodule

// ----- rtl/rgba_mipmap_box_downsample.sv -----
// Top level of the RGBA mipmap 2x2 box downsampler: counters, row buffer,
// four channel lanes and the output register. Depends on rmbd_pkg,
// rmbd_lane and rmbd_ram.
// Results pass through the s1 stage and the output register; one request per cycle while req_stall is low.
// The rate is set by the single row buffer port pair, at most one access per request.
// Reset clears counters, valids and sets both dimensions to 1024.
// The row buffer is not cleared; odd rows only read entries written above.
module rgba_mipmap_box_downsample (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rmbd_pkg::chan_type                 req_red,
   input  rmbd_pkg::chan_type                 req_green,
   input  rmbd_pkg::chan_type                 req_blue,
   input  rmbd_pkg::chan_type                 req_alpha,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rmbd_pkg::chan_type                 rsp_red_avg,
   output rmbd_pkg::chan_type                 rsp_green_avg,
   output rmbd_pkg::chan_type                 rsp_blue_avg,
   output rmbd_pkg::chan_type                 rsp_alpha_avg,
   output logic                               rsp_image_done,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rmbd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rmbd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rmbd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import rmbd_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [NUM_CH*CH_W-1:0] held_ff, held_in;
   logic s1_vld_ff, s1_vld_in;
   logic s1_done_ff, s1_done_in;
   logic [ROW_W-1:0] s1_pair_ff, s1_pair_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_done_ff, rsp_done_in;
   logic [NUM_CH*CH_W-1:0] rsp_data_ff, rsp_data_in;

   logic csr_write;
   reg_index_type csr_index;
   logic [EXT_W-1:0] eff_w, eff_h, col_ext, row_ext;
   logic accept, s1_free, out_free, odd_col, odd_row, produce, done_now;
   logic ram_wr, ram_rd;
   logic [ADDR_W-1:0] ram_addr;
   logic [ROW_W-1:0] pair_now, above;
   logic [NUM_CH*CH_W-1:0] pix_now, avg_all;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign width_in = (csr_write && csr_index == REG_IMAGE_WIDTH) ?
                     csr_pwdata[DIM_W-1:0] : width_ff;
   assign height_in = (csr_write && csr_index == REG_IMAGE_HEIGHT) ?
                      csr_pwdata[DIM_W-1:0] : height_ff;

   assign eff_w = clamp_dim(width_ff);
   assign eff_h = clamp_dim(height_ff);
   assign col_ext = EXT_W'(col_ff);
   assign row_ext = EXT_W'(row_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_free = !s1_vld_ff || out_free;
   assign req_stall = !s1_free;
   assign accept = req_valid && s1_free;

   assign odd_col = col_ff[0];
   assign odd_row = row_ff[0];
   assign produce = odd_col && odd_row;
   assign done_now = (col_ext == (eff_w & ~EXT_W'(1))- EXT_W'(1)) &&
                     (row_ext == (eff_h & ~EXT_W'(1)) - EXT_W'(1));

   assign pix_now = {req_alpha, req_blue, req_green, req_red};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ext + EXT_W'(1) >= eff_w) begin
            col_in = '0;
            row_in = (row_ext + EXT_W'(1) >= eff_h) ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   assign held_in = (accept && !odd_col) ? pix_now : held_ff;

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      rmbd_lane u_lane (
         .left_byte  (held_ff[ch*CH_W +: CH_W]),
         .right_byte (pix_now[ch*CH_W +: CH_W]),
         .pair_sum   (pair_now[ch*PAIR_W +: PAIR_W]),
         .lower_pair (s1_pair_ff[ch*PAIR_W +: PAIR_W]),
         .upper_pair (above[ch*PAIR_W +: PAIR_W]),
         .avg        (avg_all[ch*CH_W +: CH_W])
      );
   end

   assign ram_wr = accept && odd_col && !odd_row;
   assign ram_rd = accept && produce;
   assign ram_addr = ADDR_W'(col_ff >> 1);

   rmbd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUF_DEPTH)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_addr),
      .wr_data (pair_now),
      .rd_en   (ram_rd),
      .rd_addr (ram_addr),
      .rd_data (above)
   );

   assign s1_vld_in = s1_free ? ram_rd : s1_vld_ff;
   assign s1_pair_in = ram_rd ? pair_now : s1_pair_ff;
   assign s1_done_in = ram_rd ? done_now : s1_done_ff;

   assign rsp_valid_in = out_free ? s1_vld_ff : rsp_valid_ff;
   assign rsp_data_in = (out_free && s1_vld_ff) ? avg_all : rsp_data_ff;
   assign rsp_done_in = (out_free && s1_vld_ff) ? s1_done_ff : rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
         held_ff <= '0;
         s1_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         held_ff <= held_in;
         s1_vld_ff <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff <= s1_pair_in;
      s1_done_ff <= s1_done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red_avg = rsp_data_ff[0*CH_W +: CH_W];
   assign rsp_green_avg = rsp_data_ff[1*CH_W +: CH_W];
   assign rsp_blue_avg = rsp_data_ff[2*CH_W +: CH_W];
   assign rsp_alpha_avg = rsp_data_ff[3*CH_W +: CH_W];
   assign rsp_image_done = rsp_done_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

   a_buf_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr && ram_rd))
      else $error("row buffer written and read in the same cycle");

   a_read_reaches_s1: assert property (@(posedge clock) disable iff (reset)
      ram_rd |=> s1_vld_ff)
      else $error("odd row pair sum lost before the averaging stage");

   a_s1_to_output: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && out_free) |=> rsp_valid_ff)
      else $error("averaged pixel not loaded into the output register");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for rgba_mipmap_box_downsample: directed rows, some with fixed
// averages, then random images of many sizes, checked against a 2x2 box-average predictor
// kept in this file. Depends on rmbd_pkg and the rtl top level; reads and writes no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rmbd_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT = 20000;
   localparam int HOLD_CYCLES = 250;
   localparam int RANDOM_REQUESTS = 500;

   typedef struct packed {
      chan_type alpha;
      chan_type blue;
      chan_type green;
      chan_type red;
   } rgba_t;

   typedef struct packed {
      logic     done;
      chan_type alpha;
      chan_type blue;
      chan_type green;
      chan_type red;
   } texel_t;

   typedef logic [NUM_CH-1:0][PAIR_W-1:0] lane_sums_t;

   typedef struct packed {
      bit               is_dim;
      reg_index_type    dim_sel;
      logic [DIM_W-1:0] dim_value;
      rgba_t            pix;
      bit               typed;
      texel_t           want;
   } stim_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   chan_type              req_red = '0;
   chan_type              req_green = '0;
   chan_type              req_blue = '0;
   chan_type              req_alpha = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   chan_type              rsp_red_avg;
   chan_type              rsp_green_avg;
   chan_type              rsp_blue_avg;
   chan_type              rsp_alpha_avg;
   logic                  rsp_image_done;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rgba_mipmap_box_downsample dut (.*);

   logic [DIM_W-1:0] width_setting = WIDTH_RESET;
   logic [DIM_W-1:0] height_setting = HEIGHT_RESET;
   lane_sums_t       pair_sums [BUF_DEPTH];
   rgba_t            held_pixel = '0;
   int               col_pos = 0;
   int               row_pos = 0;

   texel_t expected_texels [$];
   int     errors = 0;
   int     pixels_sent = 0;
   int     texels_checked = 0;
   int     image_ends = 0;
   int     settings_used = 0;
   bit     sender_gaps = 1'b1;
   bit     receiver_gaps = 1'b1;
   bit     hold_off_request = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("rgba_mipmap_box_downsample verification failed");
      $finish;
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      texel_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_texels.size() == 0) begin
            $error("averaged pixel arrived with no request waiting for it");
            errors++;
         end else begin
            want = expected_texels.pop_front();
            compare_field("red_avg", want.red, rsp_red_avg);
            compare_field("green_avg", want.green, rsp_green_avg);
            compare_field("blue_avg", want.blue, rsp_blue_avg);
            compare_field("alpha_avg", want.alpha, rsp_alpha_avg);
            compare_field("image_done", want.done, rsp_image_done);
            texels_checked++;
            if (rsp_image_done) begin
               image_ends++;
            end
         end
      end
   end

   function automatic int dim_limit(logic [DIM_W-1:0] v);
      if (v > DIM_W'(MAX_WIDTH)) begin
         return MAX_WIDTH;
      end
      return (v == '0) ? 1 : int'(v);
   endfunction

   function automatic bit box_filter_predict(input rgba_t px, output texel_t tx);
      logic [NUM_CH-1:0][CH_W-1:0] left_ch;
      logic [NUM_CH-1:0][CH_W-1:0] cur_ch;
      logic [NUM_CH-1:0][CH_W-1:0] avg_ch;
      lane_sums_t pair;
      int w;
      int h;
      int slot;
      bit produced;
      w = dim_limit(width_setting);
      h = dim_limit(height_setting);
      left_ch = held_pixel;
      cur_ch = px;
      avg_ch = '0;
      produced = 1'b0;
      tx = '0;
      slot = col_pos / 2;
      if (col_pos % 2 == 0) begin
         held_pixel = px;
      end else begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            pair[ch] = PAIR_W'(left_ch[ch]) + PAIR_W'(cur_ch[ch]);
         end
         if (row_pos % 2 == 0) begin
            pair_sums[slot] = pair;
         end else begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               avg_ch[ch] = CH_W'((QUAD_W'(pair_sums[slot][ch]) + QUAD_W'(pair[ch])) >> 2);
            end
            tx = {1'b0, avg_ch};
            tx.done = (col_pos == (w / 2) * 2 - 1) && (row_pos == (h / 2) * 2 - 1);
            produced = 1'b1;
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return produced;
   endfunction

   function automatic rgba_t random_pixel();
      logic [NUM_CH-1:0][CH_W-1:0] chans;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         case ($urandom_range(0, 7))
            0: chans[ch] = '0;
            1: chans[ch] = '1;
            default: chans[ch] = CH_W'($urandom());
         endcase
      end
      return chans;
   endfunction

   task automatic send_pixel(input rgba_t px, input bit typed, input texel_t typed_want);
      texel_t tx;
      bit got;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= px.red;
      req_green <= px.green;
      req_blue <= px.blue;
      req_alpha <= px.alpha;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = box_filter_predict(px, tx);
      if (got) begin
         expected_texels.push_back(typed ? typed_want : tx);
      end
      pixels_sent++;
   endtask

   task automatic settle_block();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_texels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_texels.size() != 0) begin
         $error("%0d averaged pixels never came out", expected_texels.size());
         errors++;
         expected_texels.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input reg_index_type sel, input logic [DIM_W-1:0] value,
                             input bit is_write, output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= {(CSR_DATA_W - DIM_W)'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_dimension(input reg_index_type sel, input logic [DIM_W-1:0] want);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(sel, '0, 1'b0, rdata);
      if (rdata[DIM_W-1:0] !== want) begin
         $error("%s: expected %0d, got %0d", sel.name(), want, rdata[DIM_W-1:0]);
         errors++;
      end
   endtask

   task automatic set_dimension(input reg_index_type sel, input int value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(sel, DIM_W'(value), 1'b1, rdata);
      if (sel == REG_IMAGE_WIDTH) begin
         width_setting = DIM_W'(value);
      end else begin
         height_setting = DIM_W'(value);
      end
      settings_used++;
      check_dimension(sel, DIM_W'(value));
   endtask

   function automatic stim_row_t dims_row(reg_index_type sel, int value);
      stim_row_t s;
      s = '0;
      s.is_dim = 1'b1;
      s.dim_sel = sel;
      s.dim_value = DIM_W'(value);
      return s;
   endfunction

   function automatic stim_row_t pixel_row(int r, int g, int b, int a);
      stim_row_t s;
      s = '0;
      s.pix = {CH_W'(a), CH_W'(b), CH_W'(g), CH_W'(r)};
      return s;
   endfunction

   function automatic stim_row_t averaged_row(int r, int g, int b, int a,
                                              int wr, int wg, int wb, int wa, bit wd);
      stim_row_t s;
      s = pixel_row(r, g, b, a);
      s.typed = 1'b1;
      s.want = {wd, CH_W'(wa), CH_W'(wb), CH_W'(wg), CH_W'(wr)};
      return s;
   endfunction

   initial begin : stimulus
      stim_row_t directed_rows [$];
      int phase_no;
      int random_sent;
      int w_val;
      int h_val;
      int mode;
      int count;
      int pause_at;
      int img;
      directed_rows = '{
         dims_row(REG_IMAGE_HEIGHT, 2), dims_row(REG_IMAGE_WIDTH, 1),
         pixel_row(12, 34, 56, 78),
         dims_row(REG_IMAGE_WIDTH, 2),
         pixel_row(255, 255, 255, 255), pixel_row(255, 255, 255, 255),
         pixel_row(255, 255, 255, 255),
         averaged_row(255, 255, 255, 255, 255, 255, 255, 255, 1'b1),
         pixel_row(3, 255, 1, 128), pixel_row(0, 255, 1, 0), pixel_row(0, 255, 1, 0),
         averaged_row(0, 254, 1, 0, 0, 254, 1, 32, 1'b1),
         dims_row(REG_IMAGE_WIDTH, 4),
         pixel_row(8'hAA, 8'h55, 8'hAA, 8'h55), pixel_row(8'h55, 8'hAA, 8'h55, 8'hAA),
         pixel_row(8'hAA, 8'h55, 8'hAA, 8'h55), pixel_row(8'h55, 8'hAA, 8'h55, 8'hAA),
         pixel_row(8'h55, 8'hAA, 8'h55, 8'hAA), pixel_row(8'hAA, 8'h55, 8'hAA, 8'h55),
         pixel_row(8'h55, 8'hAA, 8'h55, 8'hAA), pixel_row(8'hAA, 8'h55, 8'hAA, 8'h55),
         dims_row(REG_IMAGE_WIDTH, 3), dims_row(REG_IMAGE_HEIGHT, 3),
         pixel_row(1, 200, 77, 254), pixel_row(2, 201, 78, 253), pixel_row(99, 9, 9, 9),
         pixel_row(3, 202, 79, 252), pixel_row(4, 203, 80, 251), pixel_row(98, 8, 8, 8),
         pixel_row(7, 7, 7, 7), pixel_row(6, 6, 6, 6), pixel_row(5, 5, 5, 5)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_dimension(REG_IMAGE_WIDTH, WIDTH_RESET);
      check_dimension(REG_IMAGE_HEIGHT, HEIGHT_RESET);

      // One full row at the reset size writes every row buffer entry, so later size
      // changes in the middle of an image never read an entry that was never written.
      repeat (MAX_WIDTH) send_pixel(random_pixel(), 1'b0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_dim) begin
            settle_block();
            set_dimension(directed_rows[i].dim_sel, directed_rows[i].dim_value);
         end else begin
            send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      phase_no = 0;
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         phase_no++;
         settle_block();
         sender_gaps = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         mode = 2;
         count = 0;
         case (phase_no)
            1: begin
               w_val = 2047;
               h_val = 2;
               count = 64;
            end
            2: begin
               w_val = 2;
               h_val = 2047;
               count = 100;
            end
            3: begin
               w_val = 0;
               h_val = 3;
               count = 9;
            end
            4: begin
               w_val = 3;
               h_val = 0;
               count = 9;
            end
            5: begin
               w_val = 1;
               h_val = 1;
               count = 5;
            end
            6: begin
               w_val = 2;
               h_val = 2;
               count = 300;
               sender_gaps = 1'b0;
            end
            default: begin
               mode = $urandom_range(0, 2);
               case ($urandom_range(0, 9))
                  0: begin
                     w_val = $urandom_range(0, 2047);
                     h_val = $urandom_range(0, 2047);
                  end
                  1, 2: begin
                     w_val = $urandom_range(0, 9);
                     h_val = $urandom_range(0, 6);
                  end
                  default: begin
                     w_val = 2 * $urandom_range(1, 8);
                     h_val = 2 * $urandom_range(1, 4);
                  end
               endcase
            end
         endcase
         if (mode != 1) begin
            set_dimension(REG_IMAGE_WIDTH, w_val);
         end
         if (mode != 0) begin
            set_dimension(REG_IMAGE_HEIGHT, h_val);
         end
         if (count == 0) begin
            img = dim_limit(width_setting) * dim_limit(height_setting);
            if (img <= 64 && $urandom_range(0, 3) != 0) begin
               count = img * $urandom_range(1, 4);
            end else begin
               count = $urandom_range(1, 64);
            end
         end
         if (phase_no == 6) begin
            hold_off_request = 1'b1;
         end
         pause_at = $urandom_range(0, 2 * count);
         for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
               settle_block();
            end
            send_pixel(random_pixel(), 1'b0, '0);
         end
         random_sent += count;
      end

      settle_block();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      set_dimension(REG_IMAGE_WIDTH, 4);
      set_dimension(REG_IMAGE_HEIGHT, 4);
      repeat (64) send_pixel(random_pixel(), 1'b0, '0);
      settle_block();

      $display("Sent %0d pixel requests over %0d size writes, widths and heights 0 to 2047.",
               pixels_sent, settings_used);
      $display("Compared %0d averaged pixels, %0d of them ending an image.",
               texels_checked, image_ends);
      if (errors == 0) begin
         $display("rgba_mipmap_box_downsample verification clean");
      end else begin
         $display("rgba_mipmap_box_downsample verification failed");
      end
      $finish;
   end

endmodule
